>>> rtl/chal_pkg.sv
// ----------------------------------------------------------------------------
// chal_pkg
// Shared types and constants for the chained hash address lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package chal_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int KEY_WIDTH_DEFAULT   = 64;

  localparam int ADDR_W  = 64;
  localparam int LINE_W  = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int HASH_SHIFT = 7;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] RES_INSERT = 2'd0;
  localparam logic [1:0] RES_FULL   = 2'd1;
  localparam logic [1:0] RES_HIT    = 2'd2;
  localparam logic [1:0] RES_MISS   = 2'd3;

  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       mod_step;
    logic       head_read;
    logic       insert_write;
    logic       link_load;
    logic       walk_read;
    logic       link_next;
    logic       res_load;
    logic [1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mod_done;
    logic is_lookup;
    logic full;
    logic link_zero;
    logic key_match;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/chal_if.sv
// ----------------------------------------------------------------------------
// chal_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface chal_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [chal_pkg::ADDR_W-1:0]     address_key;
  logic [chal_pkg::LINE_W-1:0]     line_value;

  modport source (output valid, operation, address_key, line_value, input ready);
  modport sink   (input valid, operation, address_key, line_value, output ready);
endinterface

interface chal_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [chal_pkg::INDEX_W-1:0]    entry_index;
  logic [chal_pkg::LINE_W-1:0]     line_number;
  logic                            table_full;

  modport source (output valid, hit, entry_index, line_number, table_full, input ready);
  modport sink   (input valid, hit, entry_index, line_number, table_full, output ready);
endinterface

`default_nettype wire

>>> rtl/chained_hash_address_lookup_core.sv
// Sequence: an accepted item is hashed by the bit-serial modulo unit (one hash
//   bit per cycle), then the bucket head is read; an insert writes the entry or
//   reports the table full, and a lookup walks the chain to a key match or its end.
// Throughput: one item at a time; the next item is taken once the result is
//   loaded, even while that result still waits on the output.
// Reset: synchronous; a clearing pass then empties the bucket heads one by one.
`default_nettype none

module chained_hash_address_lookup_core #(
  parameter int TABLE_DEPTH = chal_pkg::TABLE_DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = chal_pkg::KEY_WIDTH_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [chal_pkg::COUNT_W-1:0]  cfg_data,
  chal_req_if.sink                     req,
  chal_rsp_if.source                   rsp
);

  chal_pkg::cmd_t cmd;
  chal_pkg::sts_t sts;

  chal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chal_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_op    (req.operation),
    .req_key   (req.address_key),
    .req_line  (req.line_value),
    .cmd       (cmd),
    .sts       (sts),
    .res_hit   (rsp.hit),
    .res_index (rsp.entry_index),
    .res_line  (rsp.line_number),
    .res_full  (rsp.table_full)
  );

endmodule

`default_nettype wire

>>> rtl/chal_dp.sv
// ----------------------------------------------------------------------------
// chal_dp
// Datapath: table memories, bit-serial modulo unit, chain link and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chal_dp #(
  parameter int TABLE_DEPTH = chal_pkg::TABLE_DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = chal_pkg::KEY_WIDTH_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [chal_pkg::COUNT_W-1:0]   cfg_data,
  input  wire                           req_op,
  input  wire [chal_pkg::ADDR_W-1:0]    req_key,
  input  wire [chal_pkg::LINE_W-1:0]    req_line,
  input  chal_pkg::cmd_t                cmd,
  output chal_pkg::sts_t                sts,
  output logic                          res_hit,
  output logic [chal_pkg::INDEX_W-1:0]  res_index,
  output logic [chal_pkg::LINE_W-1:0]   res_line,
  output logic                          res_full
);

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW  = $clog2(TABLE_DEPTH + 1);
  localparam int CNW = $clog2(KEY_WIDTH);

  logic [KEY_WIDTH-1:0]         key_store  [TABLE_DEPTH];
  logic [chal_pkg::LINE_W-1:0]  line_store [TABLE_DEPTH];
  logic [LW-1:0]                chain_next [TABLE_DEPTH];
  logic [LW-1:0]                bucket_head[TABLE_DEPTH];

  logic [chal_pkg::COUNT_W-1:0] entry_count;
  logic [LW-1:0]                fill;
  logic [IW-1:0]                clear_addr;
  logic [CNW-1:0]               bit_cnt;

  logic                         op;
  logic [KEY_WIDTH-1:0]         key;
  logic [chal_pkg::LINE_W-1:0]  line;
  logic [KEY_WIDTH-1:0]         hash;
  logic [LW-1:0]                modulus;
  logic [LW-1:0]                rem;
  logic [LW-1:0]                link;

  logic [LW-1:0]                head_q;
  logic [KEY_WIDTH-1:0]         key_q;
  logic [chal_pkg::LINE_W-1:0]  line_q;
  logic [LW-1:0]                next_q;

  logic [KEY_WIDTH-1:0]         in_key;
  logic [31:0]                  ec_wide;
  logic [LW-1:0]                eff_count;
  logic [LW:0]                  rem_shift;
  logic [LW-1:0]                rem_next;
  logic [IW-1:0]                bucket;
  logic [IW-1:0]                fill_idx;
  logic [IW-1:0]                link_idx;
  logic [LW-1:0]                link_dec;
  logic [31:0]                  fill_wide;
  logic [31:0]                  hit_wide;

  assign in_key  = req_key[KEY_WIDTH-1:0];
  assign ec_wide = 32'(entry_count);

  always_comb begin
    if (ec_wide == 32'd0) begin
      eff_count = LW'(1);
    end else if (ec_wide > 32'(TABLE_DEPTH)) begin
      eff_count = LW'(TABLE_DEPTH);
    end else begin
      eff_count = LW'(ec_wide);
    end
  end

  // restoring remainder step, hash bits in from the top
  assign rem_shift = {rem, hash[KEY_WIDTH-1]};
  assign rem_next  = (rem_shift >= {1'b0, modulus}) ? LW'(rem_shift - {1'b0, modulus})
                                                    : LW'(rem_shift);

  assign bucket   = rem[IW-1:0];
  assign fill_idx = fill[IW-1:0];
  assign link_dec = link - LW'(1);
  assign link_idx = link_dec[IW-1:0];
  assign fill_wide = 32'(fill);
  assign hit_wide  = 32'(link_dec);

  assign sts.clear_done = (clear_addr == IW'(TABLE_DEPTH - 1));
  assign sts.mod_done   = (bit_cnt == CNW'(KEY_WIDTH - 1));
  assign sts.is_lookup  = (op == chal_pkg::OP_LOOKUP);
  assign sts.full       = (fill >= modulus);
  assign sts.link_zero  = (link == '0);
  assign sts.key_match  = (key_q == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= chal_pkg::ENTRY_COUNT_RESET;
      fill        <= '0;
      clear_addr  <= '0;
    end else begin
      if (cfg_we) begin
        entry_count <= cfg_data;
      end
      if (cmd.clear_step) begin
        clear_addr <= clear_addr + IW'(1);
      end
      if (cmd.insert_write) begin
        fill <= fill + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= req_op;
      key     <= in_key;
      line    <= req_line;
      hash    <= in_key ^ (in_key >> chal_pkg::HASH_SHIFT);
      modulus <= eff_count;
      rem     <= '0;
      bit_cnt <= '0;
    end else if (cmd.mod_step) begin
      rem     <= rem_next;
      hash    <= hash << 1;
      bit_cnt <= bit_cnt + CNW'(1);
    end
    if (cmd.link_load) begin
      link <= head_q;
    end else if (cmd.link_next) begin
      link <= next_q;
    end
  end

  // table memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      bucket_head[clear_addr] <= '0;
    end else if (cmd.insert_write) begin
      bucket_head[bucket] <= fill + LW'(1);
    end
    if (cmd.head_read) begin
      head_q <= bucket_head[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert_write) begin
      key_store[fill_idx]  <= key;
      line_store[fill_idx] <= line;
      chain_next[fill_idx] <= head_q;
    end
    if (cmd.walk_read) begin
      key_q  <= key_store[link_idx];
      line_q <= line_store[link_idx];
      next_q <= chain_next[link_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        chal_pkg::RES_INSERT: begin
          res_hit   <= 1'b1;
          res_index <= fill_wide[chal_pkg::INDEX_W-1:0];
          res_line  <= line;
          res_full  <= 1'b0;
        end
        chal_pkg::RES_FULL: begin
          res_hit   <= 1'b0;
          res_index <= '0;
          res_line  <= '0;
          res_full  <= 1'b1;
        end
        chal_pkg::RES_HIT: begin
          res_hit   <= 1'b1;
          res_index <= hit_wide[chal_pkg::INDEX_W-1:0];
          res_line  <= line_q;
          res_full  <= 1'b0;
        end
        default: begin
          res_hit   <= 1'b0;
          res_index <= '0;
          res_line  <= '0;
          res_full  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/chal_ctrl.sv
// ----------------------------------------------------------------------------
// chal_ctrl
// Controller: clearing pass, modulo sequencing, chain walk and result
// handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module chal_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  wire             rsp_ready,
  input  chal_pkg::sts_t  sts,
  output chal_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_HASH     = 3'd2;
  localparam logic [2:0] S_HEAD_RD  = 3'd3;
  localparam logic [2:0] S_HEAD_USE = 3'd4;
  localparam logic [2:0] S_WALK_CHK = 3'd5;
  localparam logic [2:0] S_WALK_CMP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd.head_read = 1'b1;
        state_next    = S_HEAD_USE;
      end
      S_HEAD_USE: begin
        if (sts.is_lookup) begin
          cmd.link_load = 1'b1;
          state_next    = S_WALK_CHK;
        end else if (out_free) begin
          cmd.res_load = 1'b1;
          if (sts.full) begin
            cmd.res_kind = chal_pkg::RES_FULL;
          end else begin
            cmd.insert_write = 1'b1;
            cmd.res_kind     = chal_pkg::RES_INSERT;
          end
          state_next = S_IDLE;
        end
      end
      S_WALK_CHK: begin
        if (!sts.link_zero) begin
          cmd.walk_read = 1'b1;
          state_next    = S_WALK_CMP;
        end else if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = chal_pkg::RES_MISS;
          state_next   = S_IDLE;
        end
      end
      S_WALK_CMP: begin
        if (!sts.key_match) begin
          cmd.link_next = 1'b1;
          state_next    = S_WALK_CHK;
        end else if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = chal_pkg::RES_HIT;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_res_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_accept_hashes: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_HASH))
    else $error("accepted item did not start hashing");

  a_hash_to_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_HASH && sts.mod_done) |=> (state == S_HEAD_RD))
    else $error("modulo end did not read the bucket head");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert_write |-> (!sts.full && !sts.is_lookup))
    else $error("insert written into a full table or on a lookup");

endmodule

`default_nettype wire
